FILE: hw/rtl/ata_tf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ata_tf_pkg
// Shared types and constants for the ATA taskfile command issuer.
// ----------------------------------------------------------------------------
package ata_tf_pkg;

    // result kinds
    typedef enum logic [2:0] {
        KIND_REG        = 3'd0,
        KIND_CMD        = 3'd1,
        KIND_BUSY       = 3'd2,
        KIND_TIMEOUT    = 3'd3,
        KIND_UNEXPECTED = 3'd4
    } kind_t;

    // taskfile register indexes
    localparam logic [2:0] REG_NONE    = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_LOW     = 3'd3;
    localparam logic [2:0] REG_MID     = 3'd4;
    localparam logic [2:0] REG_HIGH    = 3'd5;
    localparam logic [2:0] REG_DEV     = 3'd6;
    localparam logic [2:0] REG_CMD     = 3'd7;

    // command opcodes and device byte bases
    localparam logic [7:0] CMD_READ28  = 8'hC8;
    localparam logic [7:0] CMD_READ48  = 8'h25;
    localparam logic [7:0] CMD_WRITE28 = 8'hCA;
    localparam logic [7:0] CMD_WRITE48 = 8'h35;
    localparam logic [7:0] DEV_LBA28   = 8'hE0;
    localparam logic [7:0] DEV_LBA48   = 8'h40;

    // status bits
    localparam int unsigned ST_BSY_BIT  = 7;
    localparam int unsigned ST_DRDY_BIT = 6;

    // one accepted item, as handed to the write sequencer
    typedef struct packed {
        logic        start;     // 1: taskfile load, 0: single status result
        logic        lba48;
        logic        dev;
        logic [47:0] block;
        logic [15:0] count;
        kind_t       kind;      // status results only
        logic [2:0]  reg_idx;   // status results only
        logic [7:0]  value;     // status results only
    } job_t;

endpackage : ata_tf_pkg
`default_nettype wire

FILE: hw/rtl/ata_tf_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ata_tf_seq
// Holds one accepted item and walks out its register writes, or its single
// status result, one per cycle while not stalled, into an output register.
// ----------------------------------------------------------------------------
module ata_tf_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ata_tf_pkg::job_t  in_job,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // reg_index[2:0], write_value[10:3]
    output logic [2:0]             m_axis_tuser,   // kind[2:0]
    output logic                   m_axis_tlast
);
    import ata_tf_pkg::*;

    localparam logic [3:0] STEP_DEVICE  = 4'd0;
    localparam logic [3:0] STEP_CNT_HI  = 4'd1;
    localparam logic [3:0] STEP_LOW_HI  = 4'd2;
    localparam logic [3:0] STEP_MID_HI  = 4'd3;
    localparam logic [3:0] STEP_HIGH_HI = 4'd4;
    localparam logic [3:0] STEP_CNT_LO  = 4'd5;
    localparam logic [3:0] STEP_LOW_LO  = 4'd6;
    localparam logic [3:0] STEP_MID_LO  = 4'd7;
    localparam logic [3:0] STEP_HIGH_LO = 4'd8;

    job_t        job_reg;
    logic        job_valid_reg;
    logic        job_valid_next;
    logic [3:0]  step_reg;
    logic [3:0]  step_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    kind_t       out_kind_reg;
    logic [2:0]  out_idx_reg;
    logic [7:0]  out_val_reg;
    logic        out_last_reg;

    kind_t       cur_kind;
    logic [2:0]  cur_idx;
    logic [7:0]  cur_val;
    logic        cur_last;
    logic        out_load;
    logic        advance;
    logic        job_done;
    logic        in_take;

    // current result of the held item
    always_comb
    begin
        cur_kind = KIND_REG;
        cur_idx  = REG_NONE;
        cur_val  = 8'h00;
        cur_last = 1'b0;
        if (!job_reg.start)
        begin
            cur_kind = job_reg.kind;
            cur_idx  = job_reg.reg_idx;
            cur_val  = job_reg.value;
            cur_last = 1'b1;
        end
        else
        begin
            case (step_reg)
                STEP_DEVICE:
                begin
                    cur_idx = REG_DEV;
                    if (job_reg.lba48)
                        cur_val = DEV_LBA48 | {3'b000, job_reg.dev, 4'h0};
                    else
                        cur_val = DEV_LBA28 | {3'b000, job_reg.dev, job_reg.block[27:24]};
                end
                STEP_CNT_HI:  begin cur_idx = REG_COUNT; cur_val = job_reg.count[15:8];  end
                STEP_LOW_HI:  begin cur_idx = REG_LOW;   cur_val = job_reg.block[31:24]; end
                STEP_MID_HI:  begin cur_idx = REG_MID;   cur_val = job_reg.block[39:32]; end
                STEP_HIGH_HI: begin cur_idx = REG_HIGH;  cur_val = job_reg.block[47:40]; end
                STEP_CNT_LO:  begin cur_idx = REG_COUNT; cur_val = job_reg.count[7:0];   end
                STEP_LOW_LO:  begin cur_idx = REG_LOW;   cur_val = job_reg.block[7:0];   end
                STEP_MID_LO:  begin cur_idx = REG_MID;   cur_val = job_reg.block[15:8];  end
                STEP_HIGH_LO:
                begin
                    cur_idx  = REG_HIGH;
                    cur_val  = job_reg.block[23:16];
                    cur_last = 1'b1;
                end
                default:
                begin
                    cur_idx  = REG_NONE;
                    cur_last = 1'b1;
                end
            endcase
        end
    end

    // handshake between held item, output register and input side
    assign out_load = !out_valid_reg || m_axis_tready;
    assign advance  = job_valid_reg && out_load;
    assign job_done = advance && cur_last;
    assign in_ready = !job_valid_reg || job_done;
    assign in_take  = in_valid && in_ready;

    // step and item occupancy
    always_comb
    begin
        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        if (job_done)
        begin
            job_valid_next = 1'b0;
            step_next      = STEP_DEVICE;
        end
        else if (advance)
        begin
            if (step_reg == STEP_DEVICE && !job_reg.lba48)
                step_next = STEP_CNT_LO;
            else
                step_next = step_reg + 4'd1;
        end
        if (in_take)
        begin
            job_valid_next = 1'b1;
            step_next      = STEP_DEVICE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = job_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= STEP_DEVICE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            job_reg <= in_job;
        if (advance)
        begin
            out_kind_reg <= cur_kind;
            out_idx_reg  <= cur_idx;
            out_val_reg  <= cur_val;
            out_last_reg <= cur_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_val_reg, out_idx_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // an LBA28 load never visits the high-order steps
    a_lba28_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && job_reg.start && !job_reg.lba48)
            |-> (step_reg == STEP_DEVICE || step_reg >= STEP_CNT_LO))
        else $error("lba28 load entered a high-order step");

    // a status result never moves past its first step
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && !job_reg.start) |-> (step_reg == STEP_DEVICE))
        else $error("status result left its only step");

    // the step counter stays inside the write list
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_HIGH_LO)
        else $error("step counter out of range");

    // a new item is taken only when the held one is gone or finishing
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> (!job_valid_reg || (advance && cur_last)))
        else $error("item taken over a busy sequencer");
`endif

endmodule : ata_tf_seq
`default_nettype wire

FILE: hw/rtl/ata_taskfile_command_issuer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ata_taskfile_command_issuer
// Issues ATA taskfile register writes for LBA28/LBA48 DMA commands and polls
// the drive status before writing the command.
// ----------------------------------------------------------------------------
// A start transfer produces five register writes (LBA28) or nine (LBA48), one
// per cycle while tready is high; a status transfer produces one result. The
// write sequencer holds one item at a time. The next item is accepted in the
// same cycle that the previous item's last result moves into the output
// register, so items follow back to back while the consumer keeps tready
// high. Command and poll state is updated when an item is accepted. The user
// must write poll_limit only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ata_taskfile_command_issuer #(
    parameter int POLL_COUNT_WIDTH = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        poll_limit_wr_en,
    input  wire logic [19:0] poll_limit_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // block[47:0], write_not_read[48], sector_count[64:49], lba48[65],
    // device_select[66], status_byte[74:67]
    input  wire logic [79:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // op[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // reg_index[2:0], write_value[10:3]
    output logic [2:0]       m_axis_tuser,   // kind[2:0]
    output logic             m_axis_tlast
);
    import ata_tf_pkg::*;

    localparam logic [POLL_COUNT_WIDTH-1:0] POLL_RESET = POLL_COUNT_WIDTH'(100000);
    localparam logic [POLL_COUNT_WIDTH-1:0] POLL_ONE   = POLL_COUNT_WIDTH'(1);
    localparam logic [POLL_COUNT_WIDTH-1:0] POLL_ZERO  = '0;

    logic [POLL_COUNT_WIDTH-1:0] poll_limit_reg;
    logic [POLL_COUNT_WIDTH-1:0] polls_left_reg;
    logic [POLL_COUNT_WIDTH-1:0] polls_left_next;
    logic [POLL_COUNT_WIDTH-1:0] polls_dec;
    logic                        waiting_reg;
    logic                        waiting_next;
    logic [7:0]                  pending_reg;
    logic [7:0]                  pending_next;

    logic        in_op;
    logic [47:0] in_block;
    logic        in_wr;
    logic [15:0] in_count;
    logic        in_lba48;
    logic        in_dev;
    logic [7:0]  in_status;
    logic        drive_ready;
    logic        in_accept;
    job_t        job;

    // input field unpacking
    assign in_op     = s_axis_tuser;
    assign in_block  = s_axis_tdata[47:0];
    assign in_wr     = s_axis_tdata[48];
    assign in_count  = s_axis_tdata[64:49];
    assign in_lba48  = s_axis_tdata[65];
    assign in_dev    = s_axis_tdata[66];
    assign in_status = s_axis_tdata[74:67];

    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign drive_ready = !in_status[ST_BSY_BIT] && in_status[ST_DRDY_BIT];
    assign polls_dec   = polls_left_reg - POLL_ONE;

    // command state and item decode
    always_comb
    begin
        waiting_next    = waiting_reg;
        pending_next    = pending_reg;
        polls_left_next = polls_left_reg;
        job.start       = !in_op;
        job.lba48       = in_lba48;
        job.dev         = in_dev;
        job.block       = in_block;
        job.count       = in_count;
        job.kind        = KIND_UNEXPECTED;
        job.reg_idx     = REG_NONE;
        job.value       = in_status;
        if (!in_op)
        begin
            job.kind = KIND_REG;
            if (in_lba48)
                pending_next = in_wr ? CMD_WRITE48 : CMD_READ48;
            else
                pending_next = in_wr ? CMD_WRITE28 : CMD_READ28;
            waiting_next    = 1'b1;
            polls_left_next = (poll_limit_reg != POLL_ZERO) ? poll_limit_reg : POLL_ONE;
        end
        else if (!waiting_reg)
        begin
            job.kind = KIND_UNEXPECTED;
        end
        else if (drive_ready)
        begin
            job.kind     = KIND_CMD;
            job.reg_idx  = REG_CMD;
            job.value    = pending_reg;
            waiting_next = 1'b0;
        end
        else
        begin
            polls_left_next = polls_dec;
            if (polls_dec == POLL_ZERO)
            begin
                job.kind     = KIND_TIMEOUT;
                waiting_next = 1'b0;
            end
            else
            begin
                job.kind = KIND_BUSY;
            end
        end
    end

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= POLL_RESET;
            waiting_reg    <= 1'b0;
            pending_reg    <= 8'h00;
            polls_left_reg <= POLL_ZERO;
        end
        else
        begin
            if (poll_limit_wr_en)
                poll_limit_reg <= POLL_COUNT_WIDTH'(poll_limit_wr_data);
            if (in_accept)
            begin
                waiting_reg    <= waiting_next;
                pending_reg    <= pending_next;
                polls_left_reg <= polls_left_next;
            end
        end
    end

    // register write sequencer with output register
    ata_tf_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_job        (job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // while waiting for the drive at least one poll remains
    a_polls_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg |-> (polls_left_reg != POLL_ZERO))
        else $error("waiting with no polls left");

    // a start transfer always arms the wait
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_op) |=> waiting_reg)
        else $error("start transfer did not arm the wait");

    // a status transfer while idle leaves the state alone
    a_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_op && !waiting_reg)
            |=> (!waiting_reg && $stable(polls_left_reg) && $stable(pending_reg)))
        else $error("idle status transfer changed state");
`endif

endmodule : ata_taskfile_command_issuer
`default_nettype wire
